@@ hdl/pbt_pkg.sv @@
package pbt_pkg;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_W     = $clog2(PHASES);
  localparam int unsigned BTN_W       = 12;
  localparam int unsigned MAP_COUNT   = 10;
  localparam int unsigned MAP_ENTRIES = 12;
  localparam int unsigned MAP_W       = 4;
  localparam int unsigned SPEED_W     = 3;
  localparam int unsigned DIV_W       = 2;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_SELECT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [0:0] {
    CFG_MAP_SELECT          = 1'b0,
    CFG_THREE_BUTTON_COMPAT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [BTN_W-1:0] buttons;
    logic             select_level;
  } item_t;

  typedef struct packed {
    logic [MAP_W-1:0] map_select;
    logic             three_button_compat;
  } cfg_t;

  // Active-high contributions to the three port bytes.
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] x;
  } pat_t;

  typedef struct packed {
    logic [BTN_W-1:0] mask;
    pat_t             pat;
    logic             turbo;
  } map_entry_t;

  localparam logic [7:0] PORT_IDLE = 8'hff;
  localparam logic [7:0] ODD_MASK  = 8'h0c;
  localparam logic [7:0] DET_MASK  = 8'h3c;
  localparam logic [7:0] ID_MASK   = 8'h03;

  localparam logic [MAP_W-1:0]   MAP_LAST      = 4'd9;
  localparam logic [MAP_W-1:0]   MAP_JOY_FIRST = 4'd5;
  localparam logic [MAP_W-1:0]   MAP_JOY_LAST  = 4'd8;
  localparam logic [SPEED_W-1:0] SPEED_LAST    = 3'd5;

  localparam int unsigned BIT_SEL   = 2;
  localparam int unsigned BIT_START = 3;

  localparam logic [BTN_W-1:0] B_B   = 12'h001;
  localparam logic [BTN_W-1:0] B_Y   = 12'h002;
  localparam logic [BTN_W-1:0] B_SEL = 12'h004;
  localparam logic [BTN_W-1:0] B_ST  = 12'h008;
  localparam logic [BTN_W-1:0] B_UP  = 12'h010;
  localparam logic [BTN_W-1:0] B_DN  = 12'h020;
  localparam logic [BTN_W-1:0] B_LF  = 12'h040;
  localparam logic [BTN_W-1:0] B_RT  = 12'h080;
  localparam logic [BTN_W-1:0] B_A   = 12'h100;
  localparam logic [BTN_W-1:0] B_X   = 12'h200;
  localparam logic [BTN_W-1:0] B_L   = 12'h400;
  localparam logic [BTN_W-1:0] B_R   = 12'h800;

  localparam pat_t P_A  = 24'h020000;
  localparam pat_t P_B  = 24'h000200;
  localparam pat_t P_C  = 24'h000100;
  localparam pat_t P_X  = 24'h000008;
  localparam pat_t P_Y  = 24'h000010;
  localparam pat_t P_Z  = 24'h000020;
  localparam pat_t P_ST = 24'h010000;
  localparam pat_t P_MD = 24'h000004;
  localparam pat_t P_UP = 24'h202000;
  localparam pat_t P_DN = 24'h101000;
  localparam pat_t P_LF = 24'h000800;
  localparam pat_t P_RT = 24'h000400;
  localparam pat_t J_UP = 24'h202020;
  localparam pat_t J_DN = 24'h101010;
  localparam pat_t J_LF = 24'h080808;
  localparam pat_t J_RT = 24'h040404;
  localparam pat_t J_F1 = 24'h020202;
  localparam pat_t J_F2 = 24'h010101;

  localparam map_entry_t NONE_E = '{mask: '0, pat: '0, turbo: 1'b0};

  // Unused slots have an empty mask and never contribute.
  localparam map_entry_t MAP_ROM [MAP_COUNT][MAP_ENTRIES] = '{
    '{'{B_A, P_A, 1'b0}, '{B_B, P_B, 1'b0}, '{B_X, P_C, 1'b0}, '{B_Y, P_X, 1'b0},
      '{B_L, P_Y, 1'b0}, '{B_R, P_Z, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_UP, P_UP, 1'b0}, '{B_DN, P_DN, 1'b0}, '{B_LF, P_LF, 1'b0}, '{B_RT, P_RT, 1'b0}},
    '{'{B_A, P_B, 1'b0}, '{B_B, P_A, 1'b0}, '{B_X, P_X, 1'b0}, '{B_Y, P_C, 1'b0},
      '{B_L, P_Y, 1'b0}, '{B_R, P_Z, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_UP, P_UP, 1'b0}, '{B_DN, P_DN, 1'b0}, '{B_LF, P_LF, 1'b0}, '{B_RT, P_RT, 1'b0}},
    '{'{B_A, P_C, 1'b0}, '{B_B, P_B, 1'b0}, '{B_X, P_Y, 1'b0}, '{B_Y, P_A, 1'b0},
      '{B_L, P_X, 1'b0}, '{B_R, P_Z, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_UP, P_UP, 1'b0}, '{B_DN, P_DN, 1'b0}, '{B_LF, P_LF, 1'b0}, '{B_RT, P_RT, 1'b0}},
    '{'{B_X, P_A, 1'b0}, '{B_Y, P_B, 1'b0}, '{B_B, P_C, 1'b0}, '{B_A, P_X, 1'b0},
      '{B_R, P_Y, 1'b0}, '{B_L, P_Z, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_UP, P_UP, 1'b0}, '{B_DN, P_DN, 1'b0}, '{B_LF, P_LF, 1'b0}, '{B_RT, P_RT, 1'b0}},
    '{'{B_A, P_A, 1'b0}, '{B_B, P_B, 1'b0}, '{B_X, P_C, 1'b0}, '{B_Y, P_X, 1'b0},
      '{B_L, P_Y, 1'b0}, '{B_R, P_Z, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_DN, P_UP, 1'b0}, '{B_UP, P_DN, 1'b0}, '{B_RT, P_LF, 1'b0}, '{B_LF, P_RT, 1'b0}},
    '{'{B_UP, J_UP, 1'b0}, '{B_DN, J_DN, 1'b0}, '{B_LF, J_LF, 1'b0}, '{B_RT, J_RT, 1'b0},
      '{B_A | B_B, J_F1, 1'b0}, '{B_Y | B_R, J_F1, 1'b1}, '{B_X | B_L, J_F2, 1'b0},
      NONE_E, NONE_E, NONE_E, NONE_E, NONE_E},
    '{'{B_DN, J_DN, 1'b0}, '{B_LF, J_LF, 1'b0}, '{B_RT, J_RT, 1'b0}, '{B_B, J_UP, 1'b0},
      '{B_A, J_F1, 1'b0}, '{B_Y | B_R, J_F1, 1'b1}, '{B_X | B_L, J_F2, 1'b0},
      NONE_E, NONE_E, NONE_E, NONE_E, NONE_E},
    '{'{B_DN, J_DN, 1'b0}, '{B_LF, J_LF, 1'b0}, '{B_RT, J_RT, 1'b0}, '{B_A, J_UP, 1'b0},
      '{B_B, J_F1, 1'b0}, '{B_X | B_L, J_F2, 1'b0}, '{B_Y | B_R, J_F1, 1'b1},
      NONE_E, NONE_E, NONE_E, NONE_E, NONE_E},
    '{'{B_UP, J_DN, 1'b0}, '{B_DN, J_UP, 1'b0}, '{B_RT, J_LF, 1'b0}, '{B_LF, J_RT, 1'b0},
      '{B_A, J_UP, 1'b0}, '{B_B, J_F1, 1'b0}, '{B_X | B_L, J_F2, 1'b0},
      '{B_Y | B_R, J_F1, 1'b1}, NONE_E, NONE_E, NONE_E, NONE_E},
    '{'{B_A, P_B, 1'b0}, '{B_B, P_A, 1'b0}, '{B_X, P_Y, 1'b0}, '{B_Y, P_X, 1'b0},
      '{B_L, P_Z, 1'b0}, '{B_R, P_C, 1'b0}, '{B_ST, P_ST, 1'b0}, '{B_SEL, P_MD, 1'b0},
      '{B_UP, P_UP, 1'b0}, '{B_DN, P_DN, 1'b0}, '{B_LF, P_LF, 1'b0}, '{B_RT, P_RT, 1'b0}}
  };

endpackage

@@ hdl/pad_button_translator.sv @@
// Pad button translator: takes one word per clock cycle unless the output side stalls, and returns
// exactly one result word per input word; an input register and then a result register hold the
// words and all mapping between them is a single pass of OR logic over the selected table of the
// built-in mapping ROM, so the sustained rate is one word per cycle when the output is not stalled.
// A report word stores the pressed buttons and recomposes the eight-phase port table, a select
// edge word drives the byte at the current phase and advances it, and a tick word runs the turbo
// divider and, in joystick maps, the turbo lock and speed controls. Buttons read as released until
// a report, or a tick in a joystick map, finds no button held. Configuration writes take effect at
// once and must only be made while no word is in flight.
module pad_button_translator
  import pbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [MAP_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [BTN_W-1:0]   buttons_i,
  input  logic               select_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         port_value_o,
  output logic [PHASE_W-1:0] phase_o,
  output logic               turbo_level_o
);

  cfg_t  cfg_q;
  logic  item_valid;
  item_t item;
  logic  eng_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MAP_SELECT:          cfg_q.map_select <= cfg_data_i;
        CFG_THREE_BUTTON_COMPAT: cfg_q.three_button_compat <= cfg_data_i[0];
        default:                 cfg_q <= cfg_q;
      endcase
    end
  end

  pbt_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .buttons_i      (buttons_i),
    .select_level_i (select_level_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .eng_ready_i    (eng_ready)
  );

  pbt_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .eng_ready_o   (eng_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .port_value_o  (port_value_o),
    .phase_o       (phase_o),
    .turbo_level_o (turbo_level_o)
  );

endmodule

@@ hdl/pbt_in_stage.sv @@
module pbt_in_stage
  import pbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [BTN_W-1:0] buttons_i,
  input  logic             select_level_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  logic             eng_ready_i
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || eng_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{opcode: opcode_e'(opcode_i), buttons: buttons_i,
                  select_level: select_level_i};
    end
  end

endmodule

@@ hdl/pbt_engine.sv @@
module pbt_engine
  import pbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               eng_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         port_value_o,
  output logic [PHASE_W-1:0] phase_o,
  output logic               turbo_level_o
);

  logic [BTN_W-1:0]   held_q, held_d;
  pat_t               pat_q, pat_d;
  logic               tcompat_q, tcompat_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               ignore_q, ignore_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic               lock_q, lock_d;
  logic               wave_q, wave_d;
  logic [DIV_W-1:0]   div_q, div_d;
  logic               prev_sel_q, prev_sel_d;
  logic               prev_st_q, prev_st_d;
  logic               out_valid_q;
  logic [7:0]         port_q, port_d;

  logic               fire;
  logic [MAP_W-1:0]   map_idx;
  logic               joy;
  logic               div_zero;
  logic [DIV_W-1:0]   top_m1;
  logic               wave_tick;
  logic [DIV_W-1:0]   div_tick;
  logic               lock_tick;
  logic               st_btn, sel_btn;
  logic [BTN_W-1:0]   c_held;
  logic               c_lock, c_wave;
  logic               c_ignore;
  pat_t               c_pat;

  function automatic logic [7:0] byte_at(logic [PHASE_W-1:0] idx, pat_t p, logic compat);
    logic [7:0] v;
    v = idx[0] ? (p.lo | ODD_MASK) : p.hi;
    if (!compat) begin
      case (idx)
        3'd5:    v = p.lo | DET_MASK;
        3'd6:    v = p.x;
        3'd7:    v = p.hi & ID_MASK;
        default: v = v;
      endcase
    end
    return ~v;
  endfunction

  assign eng_ready_o = !out_valid_q || out_ready_i;
  assign fire        = item_valid_i && eng_ready_o;

  assign map_idx = (cfg_i.map_select > MAP_LAST) ? '0 : cfg_i.map_select;
  assign joy     = (map_idx >= MAP_JOY_FIRST) && (map_idx <= MAP_JOY_LAST);

  always_comb begin
    case (speed_q)
      3'd2, 3'd3: top_m1 = 2'd2;
      3'd4, 3'd5: top_m1 = 2'd3;
      default:    top_m1 = 2'd1;
    endcase
  end

  assign div_zero  = (div_q == '0);
  assign wave_tick = wave_q ^ div_zero;
  assign div_tick  = div_zero ? top_m1 : div_q - 2'd1;
  assign st_btn    = held_q[BIT_START];
  assign sel_btn   = held_q[BIT_SEL];
  assign lock_tick = lock_q ^ (st_btn && !prev_st_q);

  // A report composes from the new buttons; a tick composes with the updated turbo state.
  assign c_held   = (item_i.opcode == OP_REPORT) ? item_i.buttons : held_q;
  assign c_lock   = (item_i.opcode == OP_TICK) ? lock_tick : lock_q;
  assign c_wave   = (item_i.opcode == OP_TICK) ? wave_tick : wave_q;
  assign c_ignore = (c_held == '0) ? 1'b0 : ignore_q;

  always_comb begin
    logic on;
    c_pat = '0;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      on = (MAP_ROM[map_idx][i].turbo && c_lock && c_wave)
        || (((c_held & MAP_ROM[map_idx][i].mask) != '0)
            && (!MAP_ROM[map_idx][i].turbo || c_wave));
      if (on && !c_ignore) begin
        c_pat = c_pat | MAP_ROM[map_idx][i].pat;
      end
    end
  end

  always_comb begin
    held_d     = held_q;
    pat_d      = pat_q;
    tcompat_d  = tcompat_q;
    phase_d    = phase_q;
    ignore_d   = ignore_q;
    speed_d    = speed_q;
    lock_d     = lock_q;
    wave_d     = wave_q;
    div_d      = div_q;
    prev_sel_d = prev_sel_q;
    prev_st_d  = prev_st_q;
    port_d     = PORT_IDLE;
    case (item_i.opcode)
      OP_REPORT: begin
        held_d    = item_i.buttons;
        pat_d     = c_pat;
        tcompat_d = cfg_i.three_button_compat;
        ignore_d  = c_ignore;
        phase_d   = item_i.select_level ? PHASE_W'(1) : '0;
        port_d    = byte_at(item_i.select_level ? '0 : PHASE_W'(1), c_pat,
                            cfg_i.three_button_compat);
      end
      OP_SELECT: begin
        port_d  = byte_at(phase_q, pat_q, tcompat_q);
        phase_d = phase_q + PHASE_W'(1);
      end
      OP_TICK: begin
        wave_d = wave_tick;
        div_d  = div_tick;
        if (joy) begin
          lock_d     = lock_tick;
          prev_st_d  = st_btn;
          pat_d      = c_pat;
          tcompat_d  = cfg_i.three_button_compat;
          ignore_d   = c_ignore;
          prev_sel_d = sel_btn;
          port_d     = ~c_pat.hi;
          if (sel_btn && !prev_sel_q) begin
            speed_d = (speed_q >= SPEED_LAST) ? '0 : speed_q + SPEED_W'(1);
          end
        end
      end
      default: begin
        port_d = PORT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pat_q       <= '0;
      tcompat_q   <= 1'b0;
      phase_q     <= PHASE_W'(1);
      ignore_q    <= 1'b1;
      speed_q     <= SPEED_W'(1);
      lock_q      <= 1'b0;
      wave_q      <= 1'b0;
      div_q       <= '0;
      prev_sel_q  <= 1'b0;
      prev_st_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (eng_ready_o) begin
        out_valid_q <= item_valid_i;
      end
      if (fire) begin
        held_q     <= held_d;
        pat_q      <= pat_d;
        tcompat_q  <= tcompat_d;
        phase_q    <= phase_d;
        ignore_q   <= ignore_d;
        speed_q    <= speed_d;
        lock_q     <= lock_d;
        wave_q     <= wave_d;
        div_q      <= div_d;
        prev_sel_q <= prev_sel_d;
        prev_st_q  <= prev_st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      port_q <= port_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign port_value_o  = port_q;
  assign phase_o       = phase_q;
  assign turbo_level_o = wave_q;

`ifndef SYNTHESIS
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= SPEED_LAST)
    else $error("turbo speed index out of range");

  a_select_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.opcode == OP_SELECT |=> phase_q == $past(phase_q) + PHASE_W'(1))
    else $error("select edge did not advance the phase");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted word produced no result");

  a_unused_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.opcode == OP_NONE |=> port_q == PORT_IDLE && $stable(phase_q)
      && $stable(wave_q) && $stable(pat_q))
    else $error("unused opcode changed state");
`endif

endmodule
